### rtl/sm4_pkg.sv
// Shared constants and round-function helpers for the SM4 cipher.
package sm4_pkg;

    localparam int ROUNDS    = 32;
    localparam int WORD_W    = 32;
    localparam int BLOCK_W   = 128;
    localparam int HALF_W    = 64;
    localparam int RK_ADDR_W = $clog2(ROUNDS);

    // Configuration register indexes.
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    localparam logic [WORD_W-1:0] FK0 = 32'hA3B1BAC6;
    localparam logic [WORD_W-1:0] FK1 = 32'h56AA3350;
    localparam logic [WORD_W-1:0] FK2 = 32'h677D9197;
    localparam logic [WORD_W-1:0] FK3 = 32'hB27022DC;

    localparam logic [7:0] SBOX [0:255] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    // Byte-wise S-box substitution.
    function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] x);
        return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [WORD_W-1:0] l_data(input logic [WORD_W-1:0] b);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [WORD_W-1:0] l_key(input logic [WORD_W-1:0] b);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // CK constant for round i: byte j is (4*i + j) * 7 modulo 256.
    function automatic logic [WORD_W-1:0] ck_word(input logic [RK_ADDR_W-1:0] i);
        logic [7:0]        base;
        logic [WORD_W-1:0] w;
        base = {1'b0, i, 2'b00};
        w    = '0;
        for (int j = 0; j < 4; j++) begin
            w[WORD_W-1-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
        end
        return w;
    endfunction

endpackage

### rtl/sm4_block_cipher.sv
// Top level of the SM4 block cipher: control sequencer, key registers and result register.
//
// The key is written through the configuration port: cfg_index selects key_high (key bytes
// 0 to 7) or key_low (bytes 8 to 15), and a write takes effect at the clock edge where
// cfg_we is high. Any key write marks the round-key schedule stale. Keys must be written only
// while the block is idle; the block itself does not enforce this.
// Each input item (s_data_high, s_data_low, s_kind) is one 128-bit block in big-endian byte
// order with a direction bit (0 encrypt, 1 decrypt). Each produces exactly one result item
// on m_out_high and m_out_low.
// The 32 round keys live in a small synchronous RAM with registered read data. The first
// item after reset or after a key write first runs the key schedule, one round key per cycle
// written into the RAM. A data item then takes a prefetch step that reads the first round
// key, 32 round steps that each read the next key from the RAM, and a final step that loads
// the result register. A new item is accepted only once the previous one has left the final
// step and the block is idle again.
// The result register decouples the two sides: the next item is accepted while a result
// still waits; if the receiver stalls, the finished item waits in the last step until the
// register frees. Reset (aresetn low, synchronous) clears the keys to zero, marks the
// schedule stale and drops any item in flight.
module sm4_block_cipher (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration write port
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [sm4_pkg::HALF_W-1:0]   cfg_wdata,
    // Input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sm4_pkg::HALF_W-1:0]   s_data_high,
    input  logic [sm4_pkg::HALF_W-1:0]   s_data_low,
    input  logic                         s_kind,
    // Result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sm4_pkg::HALF_W-1:0]   m_out_high,
    output logic [sm4_pkg::HALF_W-1:0]   m_out_low
);
    import sm4_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PRIME,
        ST_ROUND,
        ST_FINISH
    } state_t;

    state_t                 state_reg;
    logic [RK_ADDR_W-1:0]   cnt_reg;
    logic                   sched_valid_reg;
    logic [HALF_W-1:0]      key_high_reg;
    logic [HALF_W-1:0]      key_low_reg;
    logic                   m_valid_reg;

    logic [BLOCK_W-1:0]     data_reg;
    logic [BLOCK_W-1:0]     kwin_reg;
    logic                   dec_reg;
    logic [HALF_W-1:0]      out_high_reg;
    logic [HALF_W-1:0]      out_low_reg;

    logic                   in_fire;
    logic                   out_free;
    logic                   last_cnt;
    logic                   key_mode;
    logic [BLOCK_W-1:0]     round_in;
    logic [WORD_W-1:0]      round_const;
    logic [BLOCK_W-1:0]     round_out;
    logic [WORD_W-1:0]      round_word;
    logic [RK_ADDR_W-1:0]   rd_step;
    logic [RK_ADDR_W-1:0]   rd_addr;
    logic [WORD_W-1:0]      rk_data;

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_fire    = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_out_high = out_high_reg;
    assign m_out_low  = out_low_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign last_cnt   = (cnt_reg == RK_ADDR_W'(ROUNDS - 1));

    // The shared round unit runs the key schedule in ST_EXPAND and data rounds otherwise.
    assign key_mode    = (state_reg == ST_EXPAND);
    assign round_in    = key_mode ? kwin_reg : data_reg;
    assign round_const = key_mode ? ck_word(cnt_reg) : rk_data;

    sm4_f_unit u_round (
        .key_mode    (key_mode),
        .state_in    (round_in),
        .round_const (round_const),
        .state_out   (round_out),
        .new_word    (round_word)
    );

    // The read address runs one round ahead so that the key for round r is on the RAM
    // output during round r. Decryption walks the keys from the top down.
    assign rd_step = (state_reg == ST_PRIME) ? '0 : cnt_reg + RK_ADDR_W'(1);
    assign rd_addr = dec_reg ? ~rd_step : rd_step;

    sm4_rk_ram u_rk_ram (
        .aclk    (aclk),
        .wr_en   (key_mode),
        .wr_addr (cnt_reg),
        .wr_data (round_word),
        .rd_addr (rd_addr),
        .rd_data (rk_data)
    );

    // Sequencer, key registers and result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            sched_valid_reg <= 1'b0;
            key_high_reg    <= '0;
            key_low_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // A finished item sets the flag; otherwise it holds until the receiver takes it.
            m_valid_reg <= (state_reg == ST_FINISH && out_free) || (m_valid_reg && !m_ready);

            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    if (in_fire) begin
                        state_reg <= sched_valid_reg ? ST_PRIME : ST_EXPAND;
                    end
                end
                ST_EXPAND: begin
                    cnt_reg <= cnt_reg + RK_ADDR_W'(1);
                    if (last_cnt) begin
                        sched_valid_reg <= 1'b1;
                        state_reg       <= ST_PRIME;
                    end
                end
                ST_PRIME: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    cnt_reg <= cnt_reg + RK_ADDR_W'(1);
                    if (last_cnt) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_KEY_HIGH: key_high_reg <= cfg_wdata;
                    CFG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                    default:      key_low_reg  <= cfg_wdata;
                endcase
                sched_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers; they carry no control meaning and need no reset.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            data_reg <= {s_data_high, s_data_low};
            dec_reg  <= s_kind;
            kwin_reg <= {key_high_reg[63:32] ^ FK0, key_high_reg[31:0] ^ FK1,
                         key_low_reg[63:32] ^ FK2, key_low_reg[31:0] ^ FK3};
        end
        if (state_reg == ST_EXPAND) begin
            kwin_reg <= round_out;
        end
        if (state_reg == ST_ROUND) begin
            data_reg <= round_out;
        end
        // The result is the final window in reverse word order.
        if (state_reg == ST_FINISH && out_free) begin
            out_high_reg <= {data_reg[31:0], data_reg[63:32]};
            out_low_reg  <= {data_reg[95:64], data_reg[127:96]};
        end
    end

endmodule

### rtl/sm4_rk_ram.sv
// Round-key store: 32 words, one write port, one read port with registered data.
module sm4_rk_ram (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [sm4_pkg::RK_ADDR_W-1:0]  wr_addr,
    input  logic [sm4_pkg::WORD_W-1:0]     wr_data,
    input  logic [sm4_pkg::RK_ADDR_W-1:0]  rd_addr,
    output logic [sm4_pkg::WORD_W-1:0]     rd_data
);
    import sm4_pkg::*;

    logic [WORD_W-1:0] mem [0:ROUNDS-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/sm4_round.sv
// One SM4 round, shared by key expansion (L' transform) and data rounds (L transform).
module sm4_f_unit (
    input  logic                          key_mode,
    input  logic [sm4_pkg::BLOCK_W-1:0]   state_in,
    input  logic [sm4_pkg::WORD_W-1:0]    round_const,
    output logic [sm4_pkg::BLOCK_W-1:0]   state_out,
    output logic [sm4_pkg::WORD_W-1:0]    new_word
);
    import sm4_pkg::*;

    logic [WORD_W-1:0] w0, w1, w2, w3;
    logic [WORD_W-1:0] sub;

    assign w0 = state_in[127:96];
    assign w1 = state_in[95:64];
    assign w2 = state_in[63:32];
    assign w3 = state_in[31:0];

    assign sub      = tau(w1 ^ w2 ^ w3 ^ round_const);
    assign new_word = w0 ^ (key_mode ? l_key(sub) : l_data(sub));

    // The four-word window slides by one word per round.
    assign state_out = {w1, w2, w3, new_word};

endmodule
